[design/dwqpi_pkg.sv]
// ----------------------------------------------------------------------------
// dwqpi_pkg
// Shared types and constants for the two-wheel quadrature PI drive.
// ----------------------------------------------------------------------------
package dwqpi_pkg;

  localparam logic [3:0] REG_PROP_GAIN   = 4'd0;
  localparam logic [3:0] REG_INT_GAIN    = 4'd1;
  localparam logic [3:0] REG_FRICTION    = 4'd2;
  localparam logic [3:0] REG_PCT_PER_V   = 4'd3;
  localparam logic [3:0] REG_SPEED_PER_C = 4'd4;
  localparam logic [3:0] REG_PWM_LIMIT   = 4'd5;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Quadrature step per {previous phase, new phase} code.
  function automatic logic signed [1:0] step_lookup(input logic [3:0] code);
    logic signed [1:0] s;
    case (code)
      4'd1, 4'd7, 4'd8, 4'd14: s = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = -2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sample;   // apply an encoder sample
    logic load;     // capture a tick's inputs
    logic wheel;    // wheel being computed
    logic [2:0] stage;  // datapath stage for the tick computation
    logic finish;   // latch held outputs for this wheel
  } dwqpi_cmd_t;

endpackage

[design/dwqpi_datapath.sv]
// ----------------------------------------------------------------------------
// dwqpi_datapath
// Position counters, PI state and the shared tick arithmetic.
// ----------------------------------------------------------------------------
module dwqpi_datapath #(
  parameter int COUNT_BITS    = 32,
  parameter int INTEGRAL_BITS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dwqpi_pkg::dwqpi_cmd_t cmd,
  input  logic [1:0]          phase_left,
  input  logic [1:0]          phase_right,
  input  logic signed [15:0]  ref_left,
  input  logic signed [15:0]  ref_right,
  input  logic [15:0]         prop_gain,
  input  logic [31:0]         integral_gain,
  input  logic [14:0]         friction_offset,
  input  logic [15:0]         percent_per_volt,
  input  logic [23:0]         speed_per_count,
  input  logic [6:0]          pwm_limit,
  output logic [31:0]         count_left,
  output logic [31:0]         count_right,
  output logic signed [15:0]  speed_left,
  output logic signed [15:0]  speed_right,
  output logic [6:0]          pwm_left,
  output logic [6:0]          pwm_right,
  output logic                reverse_left,
  output logic                reverse_right,
  output logic                brake_left,
  output logic                brake_right
);

  localparam int IB = INTEGRAL_BITS;

  logic [1:0]            phase_r [2];
  logic [COUNT_BITS-1:0] pos_r [2];
  logic [COUNT_BITS-1:0] last_r [2];
  logic signed [IB-1:0]  integ_r [2];
  logic                  lrev_r [2];
  logic signed [15:0]    ref_r [2];

  logic signed [15:0] spd_r [2];
  logic [6:0]         pwm_r [2];
  logic               rev_r [2];
  logic               brk_r [2];

  // Per-stage working registers (one wheel at a time).
  logic signed [33:0] delta_r;
  logic signed [15:0] speed_r;
  logic signed [16:0] err_r;
  logic signed [IB-1:0] ip_r;
  logic signed [33:0] pterm_r;
  logic signed [41:0] iterm_r;
  logic signed [31:0] drive_r;
  logic signed [32:0] pct_r;
  logic [63:0]        ilo_r;
  logic [63:0]        ihi_r;

  logic w;
  assign w = cmd.wheel;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Stage combinational pieces.
  logic [COUNT_BITS-1:0] du;
  logic signed [COUNT_BITS-1:0] dus;
  logic signed [63:0] dext;
  logic signed [33:0] dclamp;
  assign du   = pos_r[w] - last_r[w];
  assign dus  = du;
  assign dext = 64'(dus);
  assign dclamp = (dext > 64'sh1_0000_0000) ? 34'sh1_0000_0000 :
                  (dext < -64'sh1_0000_0000) ? -34'sh1_0000_0000 : dext[33:0];

  logic [33:0] dmag;
  logic [57:0] sprod;
  logic [41:0] smag;
  logic signed [42:0] sval;
  assign dmag  = delta_r[33] ? 34'(-delta_r) : 34'(delta_r);
  assign sprod = dmag * speed_per_count;
  assign smag  = sprod[57:16];
  assign sval  = delta_r[33] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

  logic signed [15:0] spd_sat;
  assign spd_sat = (sval > 43'sd32767) ? 16'sh7fff :
                   (sval < -43'sd32768) ? 16'sh8000 : sval[15:0];

  logic signed [16:0] err_c;
  assign err_c = 17'(ref_r[w]) - 17'(speed_r);

  logic signed [IB:0] isum;
  logic signed [IB-1:0] isat;
  assign isum = (IB+1)'(integ_r[w]) + (IB+1)'(err_r);
  assign isat = (isum[IB] != isum[IB-1]) ?
                (isum[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}}) :
                isum[IB-1:0];

  // Proportional term.
  logic [16:0] emag;
  logic [32:0] pprod;
  assign emag  = err_r[16] ? 17'(-err_r) : 17'(err_r);
  assign pprod = emag * prop_gain;

  // Integral term: magnitude split into 32-bit halves.
  logic [63:0] imag;
  assign imag = mag64(64'(ip_r));
  logic [63:0] iprod_lo, iprod_hi;
  assign iprod_lo = imag[31:0] * integral_gain;
  assign iprod_hi = imag[63:32] * integral_gain;
  logic [64:0] ir;
  assign ir = 65'(ihi_r) + 65'(ilo_r[63:32]);
  logic [41:0] ilim;
  assign ilim = (ir > 65'h100_0000_0000) ? 42'h100_0000_0000 : ir[41:0];

  logic signed [42:0] dsum;
  logic signed [31:0] dsat;
  assign dsum = 43'(pterm_r) + 43'(iterm_r);
  assign dsat = (dsum > 43'sh7fff_ffff) ? 32'sh7fff_ffff :
                (dsum < -43'sh8000_0000) ? 32'sh8000_0000 : dsum[31:0];
  logic signed [32:0] dfr;
  logic signed [31:0] dfsat;
  assign dfr = (dsat > 0) ? 33'(dsat) + 33'(friction_offset) :
               (dsat < 0) ? 33'(dsat) - 33'(friction_offset) : 33'(dsat);
  assign dfsat = (dfr[32] != dfr[31]) ? (dfr[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                      : dfr[31:0];

  logic [31:0] vmag;
  logic [47:0] vprod;
  assign vmag  = drive_r[31] ? 32'(-drive_r) : 32'(drive_r);
  assign vprod = vmag * percent_per_volt;

  logic [32:0] pmag;
  logic        prev;
  logic [6:0]  ppwm;
  assign pmag = pct_r[32] ? 33'(-pct_r) : 33'(pct_r);
  assign prev = pct_r[32];
  assign ppwm = (pmag > 33'(pwm_limit)) ? pwm_limit : pmag[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        phase_r[i] <= '0;
        pos_r[i]   <= '0;
        last_r[i]  <= '0;
        integ_r[i] <= '0;
        lrev_r[i]  <= 1'b0;
        spd_r[i]   <= '0;
        pwm_r[i]   <= '0;
        rev_r[i]   <= 1'b0;
        brk_r[i]   <= 1'b0;
      end
    end else begin
      if (cmd.sample) begin
        for (int i = 0; i < 2; i++) begin
          logic [1:0] ph;
          logic signed [1:0] s;
          ph = (i == 0) ? phase_left : phase_right;
          s  = dwqpi_pkg::step_lookup({phase_r[i], ph});
          if (s > 0) pos_r[i] <= pos_r[i] - 1'b1;
          else if (s < 0) pos_r[i] <= pos_r[i] + 1'b1;
          phase_r[i] <= ph;
          brk_r[i]   <= 1'b0;
        end
      end
      if (cmd.load) begin
        ref_r[0] <= ref_left;
        ref_r[1] <= ref_right;
      end
      case (cmd.stage)
        3'd1: begin
          delta_r   <= dclamp;
          last_r[w] <= pos_r[w];
        end
        3'd2: speed_r <= spd_sat;
        3'd3: err_r <= err_c;
        3'd4: begin
          ip_r       <= (err_r == 0) ? integ_r[w] : isat;
          integ_r[w] <= (err_r == 0) ? integ_r[w] : isat;
          pterm_r    <= err_r[16] ? -$signed({1'b0, pprod[32:12]})
                                  : $signed({1'b0, pprod[32:12]});
        end
        3'd5: begin
          ilo_r <= iprod_lo;
          ihi_r <= iprod_hi;
        end
        3'd6: iterm_r <= ip_r[IB-1] ? -$signed(ilim) : $signed(ilim);
        3'd7: drive_r <= dfsat;
        default: ;
      endcase
      if (cmd.finish) begin
        spd_r[w]  <= speed_r;
        pwm_r[w]  <= ppwm;
        rev_r[w]  <= prev;
        brk_r[w]  <= prev != lrev_r[w];
        lrev_r[w] <= prev;
      end
    end
  end

  // Percent stage runs whenever cmd.stage is zero, which covers controller step 8.
  always_ff @(posedge clk) begin
    if (cmd.stage == 3'd0)
      pct_r <= drive_r[31] ? -$signed({1'b0, vprod[47:16]}) : $signed({1'b0, vprod[47:16]});
  end

  assign count_left    = 32'(pos_r[0]);
  assign count_right   = 32'(pos_r[1]);
  assign speed_left    = spd_r[0];
  assign speed_right   = spd_r[1];
  assign pwm_left      = pwm_r[0];
  assign pwm_right     = pwm_r[1];
  assign reverse_left  = rev_r[0];
  assign reverse_right = rev_r[1];
  assign brake_left    = brk_r[0];
  assign brake_right   = brk_r[1];

endmodule

[design/dwqpi_ctrl.sv]
// ----------------------------------------------------------------------------
// dwqpi_ctrl
// Sequencer for samples, tick computations and the output handshake.
// ----------------------------------------------------------------------------
module dwqpi_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_tick_done,
  output dwqpi_pkg::dwqpi_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       wheel_r, wheel_nxt;
  logic       tick_r, tick_nxt;
  logic       accept;

  assign in_ready  = (state_r == ST_IDLE) || (state_r == ST_DONE && out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = state_r == ST_DONE;
  assign out_tick_done = tick_r;

  // Steps 1..7 run the tick stages, step 8 the percent, step 9 finish.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    wheel_nxt = wheel_r;
    tick_nxt  = tick_r;
    cmd = '0;
    cmd.wheel = wheel_r;
    case (state_r)
      ST_CALC: begin
        if (step_r <= 4'd7) cmd.stage = step_r[2:0];
        else if (step_r == 4'd9) cmd.finish = 1'b1;
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd9) begin
          step_nxt = 4'd1;
          wheel_nxt = 1'b1;
          if (wheel_r) state_nxt = ST_DONE;
        end
      end
      ST_IDLE, ST_DONE: begin
        if (state_r == ST_DONE && out_ready) state_nxt = ST_IDLE;
        if (accept) begin
          tick_nxt = in_op;
          if (in_op == dwqpi_pkg::OP_TICK) begin
            cmd.load  = 1'b1;
            state_nxt = ST_CALC;
            step_nxt  = 4'd1;
            wheel_nxt = 1'b0;
          end else begin
            cmd.sample = 1'b1;
            state_nxt  = ST_DONE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 4'd1;
      wheel_r <= 1'b0;
      tick_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      wheel_r <= wheel_nxt;
      tick_r  <= tick_nxt;
    end
  end

  a_no_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CALC |-> !in_ready) else $error("input taken during tick compute");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CALC |-> (step_r >= 4'd1 && step_r <= 4'd9)) else $error("bad step");

endmodule

[design/dual_wheel_quadrature_pi_drive.sv]
// ----------------------------------------------------------------------------
// dual_wheel_quadrature_pi_drive
// Two-wheel quadrature decoder with a fixed-point PI speed loop.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake
//  in_*     | input     | in_valid / in_ready
//  out_*    | output    | out_valid / out_ready
//  cfg_*    | input     | cfg_we, no wait
//
//  An encoder sample's result is valid in the cycle after it is taken; a control
//  tick runs nine steps of the shared multiply datapath per wheel.
//  Reset is synchronous and clears all counts, integrals and held outputs.
//  A new item is taken in the cycle its predecessor's result is taken.
// ----------------------------------------------------------------------------
module dual_wheel_quadrature_pi_drive #(
  parameter int COUNT_BITS    = 32,
  parameter int INTEGRAL_BITS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [1:0]         in_phase_left,
  input  logic [1:0]         in_phase_right,
  input  logic signed [15:0] in_ref_left,
  input  logic signed [15:0] in_ref_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_tick_done,
  output logic signed [31:0] out_count_left,
  output logic signed [31:0] out_count_right,
  output logic signed [15:0] out_speed_left,
  output logic signed [15:0] out_speed_right,
  output logic [6:0]         out_pwm_left,
  output logic [6:0]         out_pwm_right,
  output logic               out_reverse_left,
  output logic               out_reverse_right,
  output logic               out_brake_left,
  output logic               out_brake_right,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [15:0] prop_gain_r;
  logic [31:0] int_gain_r;
  logic [14:0] friction_r;
  logic [15:0] pct_per_v_r;
  logic [23:0] spc_r;
  logic [6:0]  pwm_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r <= 16'd4096;
      int_gain_r  <= 32'd429;
      friction_r  <= 15'd44;
      pct_per_v_r <= 16'd7758;
      spc_r       <= 24'd263402;
      pwm_limit_r <= 7'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        dwqpi_pkg::REG_PROP_GAIN:   prop_gain_r <= cfg_data[15:0];
        dwqpi_pkg::REG_INT_GAIN:    int_gain_r  <= cfg_data;
        dwqpi_pkg::REG_FRICTION:    friction_r  <= cfg_data[14:0];
        dwqpi_pkg::REG_PCT_PER_V:   pct_per_v_r <= cfg_data[15:0];
        dwqpi_pkg::REG_SPEED_PER_C: spc_r       <= cfg_data[23:0];
        dwqpi_pkg::REG_PWM_LIMIT:   pwm_limit_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  dwqpi_pkg::dwqpi_cmd_t cmd;

  dwqpi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tick_done(out_tick_done), .cmd(cmd)
  );

  dwqpi_datapath #(.COUNT_BITS(COUNT_BITS), .INTEGRAL_BITS(INTEGRAL_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .phase_left(in_phase_left), .phase_right(in_phase_right),
    .ref_left(in_ref_left), .ref_right(in_ref_right),
    .prop_gain(prop_gain_r), .integral_gain(int_gain_r),
    .friction_offset(friction_r), .percent_per_volt(pct_per_v_r),
    .speed_per_count(spc_r), .pwm_limit(pwm_limit_r),
    .count_left(out_count_left), .count_right(out_count_right),
    .speed_left(out_speed_left), .speed_right(out_speed_right),
    .pwm_left(out_pwm_left), .pwm_right(out_pwm_right),
    .reverse_left(out_reverse_left), .reverse_right(out_reverse_right),
    .brake_left(out_brake_left), .brake_right(out_brake_right)
  );

endmodule
